// ----- rtl/core/gas_ppm_from_sensor_sample_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gas concentration core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GAS_PPM_FROM_SENSOR_SAMPLE_CORE_DEFINES_SVH
`define GAS_PPM_FROM_SENSOR_SAMPLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define GPFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gpfs assertion failed");
// condition never holds out of reset
`define GPFS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("gpfs forbidden condition seen");
`else
`define GPFS_ASSERT(lbl, prop)
`define GPFS_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- rtl/core/gpfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gpfs_pkg
// Types, constants and curve table shared by the gas concentration core.
// ----------------------------------------------------------------------------
package gpfs_pkg;

  // divider and log unit widths
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DVS_W = 32;
  localparam int unsigned LOG_W = 21;

  // log10(2) in Q0.30, stored in 29 bits
  localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;
  // log10(65536) in Q16.16 as the log unit computes it
  localparam logic signed [23:0] LOG10_65536 = 24'sd315652;
  // 16 fraction bits of the ratio, Q16.16
  localparam logic [21:0] RATIO_FBITS_Q16 = 22'd1048576;

  // gas index ranges
  localparam logic [3:0] GAS_A_LAST = 4'd5;
  localparam logic [3:0] GAS_B_LAST = 4'd8;
  localparam logic [3:0] GAS_LAST   = 4'd11;

  // request queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LOAD_RES = 2'd0,
    REG_RO_A     = 2'd1,
    REG_RO_B     = 2'd2,
    REG_RO_C     = 2'd3
  } gpfs_reg_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_SAMPLE = 2'd1,
    ST_ZERO_RES    = 2'd2,
    ST_SAT         = 2'd3
  } gpfs_status_e;

  typedef enum logic [1:0] {
    K_CALC,
    K_ZERO_SAMPLE,
    K_NO_CURVE
  } gpfs_kind_e;

  typedef enum logic [1:0] {
    SENSOR_A,
    SENSOR_B,
    SENSOR_C
  } gpfs_sensor_e;

  typedef struct packed {
    logic [9:0]   sample;
    logic [3:0]   gas;
    gpfs_kind_e   kind;
    gpfs_sensor_e sensor;
  } gpfs_entry_t;

  typedef struct packed {
    logic        push;
    gpfs_entry_t entry;
  } gpfs_push_t;

  typedef struct packed {
    logic [7:0]  load_res;
    logic [31:0] ro_a;
    logic [31:0] ro_b;
    logic [31:0] ro_c;
  } gpfs_cfg_t;

  typedef struct packed {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] m;
  } gpfs_curve_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } gpfs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } gpfs_div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } gpfs_log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] log2;
  } gpfs_log_rsp_t;

  // curve (x, y, m) per gas, Q16.16
  function automatic gpfs_curve_t gpfs_curve(input logic [3:0] gas);
    gpfs_curve_t c;
    case (gas)
      4'd0:    c = '{x: 19'sd150733, y: 19'sd13763, m: -19'sd30802};
      4'd1:    c = '{x: 19'sd150733, y: 19'sd47186, m: -19'sd22282};
      4'd2:    c = '{x: 19'sd150733, y: 19'sd30802, m: -19'sd24248};
      4'd3:    c = '{x: 19'sd150733, y: 19'sd20972, m: -19'sd34734};
      4'd4:    c = '{x: 19'sd150733, y: 19'sd30147, m: -19'sd26870};
      4'd5:    c = '{x: 19'sd150733, y: 19'sd15073, m: -19'sd29491};
      4'd6:    c = '{x: 19'sd45875,  y: 19'sd62259, m: -19'sd20316};
      4'd7:    c = '{x: 19'sd45875,  y: 19'sd58982, m: -19'sd59638};
      4'd8:    c = '{x: 19'sd45875,  y: 19'sd53084, m: -19'sd58982};
      4'd9:    c = '{x: 19'sd65536,  y: 19'sd22282, m: -19'sd21627};
      4'd10:   c = '{x: 19'sd65536,  y: 19'sd30147, m: -19'sd15729};
      4'd11:   c = '{x: 19'sd65536,  y: 19'sd26870, m: -19'sd26870};
      default: c = '{x: 19'sd0, y: 19'sd0, m: -19'sd1};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/gpfs_front.sv -----
// ----------------------------------------------------------------------------
// gpfs_front
// Accepts samples and classifies them before they enter the request queue.
// ----------------------------------------------------------------------------
module gpfs_front import gpfs_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] adc_sample_i,
  input  logic [3:0] gas_select_i,
  input  logic       fifo_full_i,
  output gpfs_push_t push_o
);

  // hold off the source while the queue is full
  assign in_stall_o = fifo_full_i;

  // classify: early results and sensor selection
  always_comb begin
    push_o.push         = in_valid_i && !fifo_full_i;
    push_o.entry.sample = adc_sample_i;
    push_o.entry.gas    = gas_select_i;
    if (adc_sample_i == '0) begin
      push_o.entry.kind = K_ZERO_SAMPLE;
    end else if (gas_select_i > GAS_LAST) begin
      push_o.entry.kind = K_NO_CURVE;
    end else begin
      push_o.entry.kind = K_CALC;
    end
    if (gas_select_i <= GAS_A_LAST) begin
      push_o.entry.sensor = SENSOR_A;
    end else if (gas_select_i <= GAS_B_LAST) begin
      push_o.entry.sensor = SENSOR_B;
    end else begin
      push_o.entry.sensor = SENSOR_C;
    end
  end

endmodule

// ----- rtl/core/gpfs_fifo.sv -----
// ----------------------------------------------------------------------------
// gpfs_fifo
// Short request queue between the front and the compute engine.
// ----------------------------------------------------------------------------
module gpfs_fifo import gpfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gpfs_push_t  push_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output gpfs_entry_t head_o
);

  gpfs_entry_t      mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // write at the tail, advance pointers, track fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        mem_q[i] <= '0;
      end
    end else begin
      if (push_i.push) begin
        mem_q[wr_ptr_q] <= push_i.entry;
        wr_ptr_q        <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i.push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/gpfs_div.sv -----
// ----------------------------------------------------------------------------
// gpfs_div
// Restoring divider, one quotient bit per cycle, shared by the engine.
// ----------------------------------------------------------------------------
module gpfs_div import gpfs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gpfs_div_req_t req_i,
  output gpfs_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W-1:0] rem_n;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_n  = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

  // load on start, shift quotient bits into the dividend register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvd_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
        cnt_q  <= CNT_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DIV_W-2:0], ge};
        rem_q <= rem_n;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/gpfs_log2.sv -----
// ----------------------------------------------------------------------------
// gpfs_log2
// Q5.16 log2 of a 32-bit value: stepped normalize, then 16 squarings.
// ----------------------------------------------------------------------------
module gpfs_log2 import gpfs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gpfs_log_req_t req_i,
  output gpfs_log_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQR
  } log_state_e;

  log_state_e  state_q;
  logic [31:0] man_q;
  logic [4:0]  lead_q;
  logic [15:0] frac_q;
  logic [3:0]  cnt_q;
  logic        done_q;

  logic [61:0] sq;
  logic [31:0] sq_t;

  // square the Q1.30 mantissa, back to Q1.30 scale
  always_comb begin
    sq   = 62'(man_q[30:0]) * 62'(man_q[30:0]);
    sq_t = sq[61:30];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.log2 = {lead_q, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      man_q   <= '0;
      lead_q  <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            man_q   <= req_i.value;
            lead_q  <= 5'd31;
            frac_q  <= '0;
            state_q <= L_NORM;
          end
        end
        // shift the leading one up to the top bit
        L_NORM: begin
          if (man_q[31:24] == '0 && lead_q >= 5'd8) begin
            man_q  <= {man_q[23:0], 8'b0};
            lead_q <= lead_q - 5'd8;
          end else if (man_q[31:28] == '0 && lead_q >= 5'd4) begin
            man_q  <= {man_q[27:0], 4'b0};
            lead_q <= lead_q - 5'd4;
          end else if (!man_q[31] && lead_q != '0) begin
            man_q  <= {man_q[30:0], 1'b0};
            lead_q <= lead_q - 5'd1;
          end else begin
            man_q   <= {1'b0, man_q[31:1]};
            cnt_q   <= 4'd15;
            state_q <= L_SQR;
          end
        end
        // one fraction bit per squaring
        L_SQR: begin
          if (sq_t[31]) begin
            man_q <= {1'b0, sq_t[31:1]};
          end else begin
            man_q <= {1'b0, sq_t[30:0]};
          end
          frac_q <= {frac_q[14:0], sq_t[31]};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/gpfs_back.sv -----
// ----------------------------------------------------------------------------
// gpfs_back
// Compute engine: resistance, ratio, log10, curve, successive approximation.
// ----------------------------------------------------------------------------
`include "gas_ppm_from_sensor_sample_core_defines.svh"

module gpfs_back import gpfs_pkg::*; #(
  parameter int unsigned ADC_FULL_SCALE = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gpfs_cfg_t   cfg_i,
  input  logic        fifo_empty_i,
  input  gpfs_entry_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] ppm_o,
  output logic [1:0]  status_o
);

  localparam logic [DIV_W-1:0] FS_DIVIDEND = DIV_W'(ADC_FULL_SCALE) << 16;
  localparam logic [31:0]      ONE_Q16     = 32'd65536;
  localparam logic [15:0]      PPM_TOP     = 16'h8000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVQ,
    S_RS,
    S_DIVR,
    S_LOG,
    S_SCALE,
    S_DIVE,
    S_WDIVE,
    S_CHK,
    S_CMP,
    S_DONE
  } back_state_e;

  back_state_e        state_q;
  gpfs_entry_t        ent_q;
  logic [31:0]        qm_q;
  logic [LOG_W-1:0]   log2_q;
  logic signed [20:0] lg_q;
  logic signed [23:0] e_q;
  logic               neg_q;
  logic               sar_q;
  logic [15:0]        ppm_q;
  logic [15:0]        cand_q;
  logic [3:0]         bit_q;
  logic [15:0]        res_ppm_q;
  gpfs_status_e       res_status_q;
  logic               out_valid_q;
  logic [15:0]        out_ppm_q;
  gpfs_status_e       out_status_q;
  gpfs_div_req_t      div_req_q;
  gpfs_div_rsp_t      div_rsp;
  gpfs_log_req_t      log_req_q;
  gpfs_log_rsp_t      log_rsp;

  gpfs_curve_t        cur;
  logic [31:0]        ro_sel;
  logic [31:0]        q_full;
  logic [31:0]        qm;
  logic [39:0]        rs;
  logic [31:0]        ratio;
  logic signed [21:0] l_s;
  logic [20:0]        mag;
  logic [49:0]        prod;
  logic [19:0]        r;
  logic signed [20:0] lg_n;
  logic signed [21:0] d;
  logic [21:0]        absd;
  logic [18:0]        abs_m;
  logic [20:0]        qe;
  logic signed [23:0] e_n;
  logic               le;
  logic [15:0]        ppm_n;
  logic [15:0]        cand_n;

  gpfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  gpfs_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req_q),
    .rsp_o  (log_rsp)
  );

  assign pop_o       = (state_q == S_IDLE) && !fifo_empty_i;
  assign out_valid_o = out_valid_q;
  assign ppm_o       = out_ppm_q;
  assign status_o    = out_status_q;

  // select clean-air resistance of the sensor
  always_comb begin
    unique case (ent_q.sensor)
      SENSOR_A: ro_sel = cfg_i.ro_a;
      SENSOR_B: ro_sel = cfg_i.ro_b;
      SENSOR_C: ro_sel = cfg_i.ro_c;
      default:  ro_sel = '0;
    endcase
  end

  // datapath between the sequencer registers
  always_comb begin
    cur    = gpfs_curve(ent_q.gas);
    q_full = div_rsp.quot[31:0];
    qm     = (q_full > ONE_Q16) ? q_full - ONE_Q16 : '0;
    rs     = 40'(qm_q) * 40'(cfg_i.load_res);
    ratio  = (div_rsp.quot[63:32] != '0) ? '1 : div_rsp.quot[31:0];
    // log2 to log10, magnitude truncated, sign restored
    l_s    = $signed({1'b0, log2_q}) - $signed(sar_q ? 22'd0 : RATIO_FBITS_Q16);
    mag    = l_s[21] ? 21'(-l_s) : 21'(l_s);
    prod   = 50'(mag) * 50'(LOG10_2_Q30);
    r      = prod[49:30];
    lg_n   = l_s[21] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    // curve offset and slope magnitudes
    d      = $signed({lg_q[20], lg_q}) - $signed({{3{cur.y[18]}}, cur.y});
    absd   = d[21] ? 22'(-d) : 22'(d);
    abs_m  = cur.m[18] ? 19'(-cur.m) : 19'(cur.m);
    qe     = div_rsp.quot[20:0];
    e_n    = $signed({{5{cur.x[18]}}, cur.x})
           + (neg_q ? -$signed({3'b0, qe}) : $signed({3'b0, qe}));
    // successive approximation compare
    le     = $signed({{3{lg_q[20]}}, lg_q}) <= e_q;
    ppm_n  = le ? cand_q : ppm_q;
    cand_n = ppm_n | (16'd1 << (bit_q - 4'd1));
  end

  // sequencer, divider and log requests, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ent_q        <= '0;
      qm_q         <= '0;
      log2_q       <= '0;
      lg_q         <= '0;
      e_q          <= '0;
      neg_q        <= 1'b0;
      sar_q        <= 1'b0;
      ppm_q        <= '0;
      cand_q       <= '0;
      bit_q        <= '0;
      res_ppm_q    <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_ppm_q    <= '0;
      out_status_q <= ST_OK;
      div_req_q    <= '0;
      log_req_q    <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      log_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!fifo_empty_i) begin
            ent_q <= head_i;
            case (head_i.kind)
              K_ZERO_SAMPLE: begin
                res_ppm_q    <= '0;
                res_status_q <= ST_ZERO_SAMPLE;
                state_q      <= S_DONE;
              end
              K_NO_CURVE: begin
                res_ppm_q    <= '0;
                res_status_q <= ST_ZERO_RES;
                state_q      <= S_DONE;
              end
              default: begin
                div_req_q.start    <= 1'b1;
                div_req_q.dividend <= FS_DIVIDEND;
                div_req_q.divisor  <= {22'b0, head_i.sample};
                state_q            <= S_DIVQ;
              end
            endcase
          end
        end
        S_DIVQ: begin
          if (div_rsp.done) begin
            qm_q    <= qm;
            state_q <= S_RS;
          end
        end
        S_RS: begin
          if (rs == '0 || ro_sel == '0) begin
            res_ppm_q    <= '0;
            res_status_q <= ST_ZERO_RES;
            state_q      <= S_DONE;
          end else begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= {8'b0, rs, 16'b0};
            div_req_q.divisor  <= ro_sel;
            state_q            <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_rsp.done) begin
            if (div_rsp.quot == '0) begin
              res_ppm_q    <= '0;
              res_status_q <= ST_ZERO_RES;
              state_q      <= S_DONE;
            end else begin
              log_req_q.start <= 1'b1;
              log_req_q.value <= ratio;
              sar_q           <= 1'b0;
              state_q         <= S_LOG;
            end
          end
        end
        S_LOG: begin
          if (log_rsp.done) begin
            log2_q  <= log_rsp.log2;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          lg_q    <= lg_n;
          state_q <= sar_q ? S_CMP : S_DIVE;
        end
        S_DIVE: begin
          div_req_q.start    <= 1'b1;
          div_req_q.dividend <= {26'b0, absd, 16'b0};
          div_req_q.divisor  <= {13'b0, abs_m};
          neg_q              <= d[21] ^ cur.m[18];
          state_q            <= S_WDIVE;
        end
        S_WDIVE: begin
          if (div_rsp.done) begin
            e_q     <= e_n;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (e_q >= LOG10_65536) begin
            res_ppm_q    <= 16'hFFFF;
            res_status_q <= ST_SAT;
            state_q      <= S_DONE;
          end else begin
            ppm_q           <= '0;
            bit_q           <= 4'd15;
            cand_q          <= PPM_TOP;
            log_req_q.start <= 1'b1;
            log_req_q.value <= {16'b0, PPM_TOP};
            sar_q           <= 1'b1;
            state_q         <= S_LOG;
          end
        end
        // keep or drop the candidate bit, then try the next one
        S_CMP: begin
          if (bit_q == '0) begin
            res_ppm_q    <= ppm_n;
            res_status_q <= ST_OK;
            state_q      <= S_DONE;
          end else begin
            ppm_q           <= ppm_n;
            cand_q          <= cand_n;
            bit_q           <= bit_q - 4'd1;
            log_req_q.start <= 1'b1;
            log_req_q.value <= {16'b0, cand_n};
            state_q         <= S_LOG;
          end
        end
        // hold until the output register is free
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_ppm_q    <= res_ppm_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `GPFS_ASSERT(a_sat_ppm, out_valid_q && (out_status_q == ST_SAT) |-> (out_ppm_q == 16'hFFFF))
  `GPFS_ASSERT(a_div_wait, div_rsp.done |-> (state_q == S_DIVQ || state_q == S_DIVR || state_q == S_WDIVE))
  `GPFS_ASSERT(a_pop_leaves_idle, pop_o |=> (state_q != S_IDLE))
  `GPFS_ASSERT_NEVER(a_early_ppm, out_valid_q && (out_status_q == ST_ZERO_SAMPLE || out_status_q == ST_ZERO_RES) && (out_ppm_q != '0))

endmodule

// ----- rtl/core/gas_ppm_from_sensor_sample_core.sv -----
// ----------------------------------------------------------------------------
// gas_ppm_from_sensor_sample_core
// Sensor sample to gas concentration in ppm, with configuration registers.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid_i/in_stall_o  adc_sample_i, gas_select_i
//  out       out_valid_o/out_stall_i ppm_o, status_o
//  cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Samples enter a four-entry queue at one per cycle while it has room; the
// engine pops one request at a time. A zero sample or an unknown gas goes
// from the idle state straight to the done state, skipping the computation;
// a full computation runs three bit-serial divisions and 17 log2 evaluations.
// Reset restores the register defaults.
// A stalled result holds in the output register while the queue keeps filling.
// ----------------------------------------------------------------------------
module gas_ppm_from_sensor_sample_core import gpfs_pkg::*; #(
  parameter int unsigned ADC_FULL_SCALE = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  adc_sample_i,
  input  logic [3:0]  gas_select_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] ppm_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  gpfs_cfg_t   cfg_q;
  gpfs_push_t  push;
  logic        fifo_full;
  logic        fifo_empty;
  logic        pop;
  gpfs_entry_t head;

  assign cfg_ready_o = 1'b1;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_res <= 8'd1;
      cfg_q.ro_a     <= 32'd65536;
      cfg_q.ro_b     <= 32'd65536;
      cfg_q.ro_c     <= 32'd65536;
    end else if (cfg_valid_i) begin
      unique case (gpfs_reg_e'(cfg_index_i))
        REG_LOAD_RES: cfg_q.load_res <= cfg_data_i[7:0];
        REG_RO_A:     cfg_q.ro_a     <= cfg_data_i;
        REG_RO_B:     cfg_q.ro_b     <= cfg_data_i;
        REG_RO_C:     cfg_q.ro_c     <= cfg_data_i;
      endcase
    end
  end

  gpfs_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .gas_select_i (gas_select_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push)
  );

  gpfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .head_o  (head)
  );

  gpfs_back #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ppm_o        (ppm_o),
    .status_o     (status_o)
  );

endmodule

// ----- tb/gas_ppm_from_sensor_sample_core_checker.sv -----
// ----------------------------------------------------------------------------
// gas_ppm_from_sensor_sample_core_checker
// Watches the sample, result and register channels of the gas concentration
// core, computes the expected ppm and status of every accepted request in
// Q16.16 fixed point and compares them in order with the results.
// ----------------------------------------------------------------------------
module gas_ppm_from_sensor_sample_core_checker import gpfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [9:0]  adc_sample_i,
  input  logic [3:0]  gas_select_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] ppm_i,
  input  logic [1:0]  status_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_SCALE = 1023;
  localparam longint ONE        = 65536;

  typedef struct {
    logic [15:0]  ppm;
    gpfs_status_e status;
  } reading_t;

  // curve x, y, m per gas, Q16.16
  localparam longint CURVE_X [12] = '{150733, 150733, 150733, 150733, 150733, 150733,
                                      45875, 45875, 45875, 65536, 65536, 65536};
  localparam longint CURVE_Y [12] = '{13763, 47186, 30802, 20972, 30147, 15073,
                                      62259, 58982, 53084, 22282, 30147, 26870};
  localparam longint CURVE_M [12] = '{-30802, -22282, -24248, -34734, -26870, -29491,
                                      -20316, -59638, -58982, -21627, -15729, -26870};

  logic [7:0]  load_res;
  logic [31:0] ro_a, ro_b, ro_c;
  reading_t    expected_readings [$];
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_readings.size();

  // log2 of a nonzero word, Q16.16, by repeated squaring of the mantissa
  function automatic longint log2_q16(logic [31:0] v);
    int              lead;
    longint unsigned man;
    longint          frac;
    lead = 31;
    frac = 0;
    while (lead > 0 && v[lead] == 1'b0) lead--;
    if (lead <= 30) man = longint'(v) << (30 - lead);
    else man = longint'(v >> 1);
    for (int i = 15; i >= 0; i--) begin
      man = (man * man) >> 30;
      if (man >= (64'd1 << 31)) begin
        man = man >> 1;
        frac = frac | (64'sd1 << i);
      end
    end
    return lead * ONE + frac;
  endfunction

  // log10 of v / 2^fbits, rounded toward zero
  function automatic longint log10_q16(logic [31:0] v, int fbits);
    longint          l;
    longint unsigned mag;
    longint          r;
    l = log2_q16(v) - fbits * ONE;
    mag = (l < 0) ? -l : l;
    r = longint'((mag * 64'd323228497) >> 30);
    return (l < 0) ? -r : r;
  endfunction

  function automatic reading_t predict_reading(logic [9:0] sample, logic [3:0] gas);
    reading_t        rd;
    longint unsigned q, rs, ro, ratio, cand;
    longint          lg, e;
    rd.ppm = '0;
    rd.status = ST_OK;
    if (sample == 0) begin
      rd.status = ST_ZERO_SAMPLE;
      return rd;
    end
    if (gas > GAS_LAST) begin
      rd.status = ST_ZERO_RES;
      return rd;
    end
    if (gas <= GAS_A_LAST) ro = ro_a;
    else if (gas <= GAS_B_LAST) ro = ro_b;
    else ro = ro_c;
    q = (FULL_SCALE << 16) / sample;
    rs = (q > ONE) ? longint'(load_res) * (q - ONE) : 0;
    if (rs == 0 || ro == 0) begin
      rd.status = ST_ZERO_RES;
      return rd;
    end
    ratio = (rs << 16) / ro;
    if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
    if (ratio == 0) begin
      rd.status = ST_ZERO_RES;
      return rd;
    end
    lg = log10_q16(ratio[31:0], 16);
    e = ((lg - CURVE_Y[gas]) * ONE) / CURVE_M[gas] + CURVE_X[gas];
    if (e >= log10_q16(32'd65536, 0)) begin
      rd.ppm = 16'hFFFF;
      rd.status = ST_SAT;
      return rd;
    end
    // successive approximation on the concentration, top bit first
    for (int b = 15; b >= 0; b--) begin
      cand = rd.ppm | (16'd1 << b);
      if (log10_q16(cand[31:0], 0) <= e) rd.ppm = cand[15:0];
    end
    return rd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      load_res <= 8'd1;
      ro_a <= 32'd65536;
      ro_b <= 32'd65536;
      ro_c <= 32'd65536;
      mismatches <= 0;
      expected_readings.delete();
    end else begin
      // track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (gpfs_reg_e'(cfg_index_i))
          REG_LOAD_RES: load_res <= cfg_data_i[7:0];
          REG_RO_A:     ro_a <= cfg_data_i;
          REG_RO_B:     ro_b <= cfg_data_i;
          REG_RO_C:     ro_c <= cfg_data_i;
        endcase
      end
      // queue the expectation of each accepted request
      if (in_valid_i && !in_stall_i)
        expected_readings.push_back(predict_reading(adc_sample_i, gas_select_i));
      // compare each accepted result with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result ppm=%0d status=%0d", ppm_i, status_i);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_readings.pop_front();
          if (want.ppm !== ppm_i || want.status !== status_i) begin
            if (mismatches < 10)
              $display("result wrong: expected ppm=%0d status=%0d, got ppm=%0d status=%0d",
                       want.ppm, want.status, ppm_i, status_i);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/gas_ppm_from_sensor_sample_core_test.sv -----
// ----------------------------------------------------------------------------
// gas_ppm_from_sensor_sample_core_test
// Drives samples and register settings into the gas concentration core under
// several idle and stall patterns; a checker beside it predicts every result.
// ----------------------------------------------------------------------------
module gas_ppm_from_sensor_sample_core_test import gpfs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [9:0]  adc_sample_i = '0;
  logic [3:0]  gas_select_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] ppm_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          idle_pct, stall_pct;

  always #10 clk_i = ~clk_i;

  gas_ppm_from_sensor_sample_core u_dut (.*);

  gas_ppm_from_sensor_sample_core_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .adc_sample_i, .gas_select_i,
    .out_valid_i(out_valid_o), .out_stall_i, .ppm_i(ppm_o), .status_i(status_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // stall the result side at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_sample(logic [9:0] sample, logic [3:0] gas);
    in_valid_i <= 1'b1;
    adc_sample_i <= sample;
    gas_select_i <= gas;
    do @(posedge clk_i); while (in_stall_o);
    // hold valid low for a random gap
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(gpfs_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [7:0] rl, logic [31:0] ra, logic [31:0] rb,
                           logic [31:0] rc);
    write_reg(REG_LOAD_RES, {24'd0, rl});
    write_reg(REG_RO_A, ra);
    write_reg(REG_RO_B, rb);
    write_reg(REG_RO_C, rc);
  endtask

  function automatic logic [31:0] random_ro();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(1, 255);
      default: return $urandom_range(32'h0000_4000, 32'h0064_0000);
    endcase
  endfunction

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every gas, special cases at reset and other settings
    send_sample(10'd0, 4'd0);
    send_sample(10'd1023, 4'd3);
    send_sample(10'd1022, 4'd15);
    send_sample(10'd1, 4'd0);
    send_sample(10'd512, 4'd12);
    for (int g = 0; g < 12; g++) send_sample(10'd100 + 10'(g * 60), 4'(g));
    wait_drained();
    write_all(8'd255, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_sample(10'd1, 4'd0);
    send_sample(10'd1, 4'd6);
    send_sample(10'd300, 4'd9);
    send_sample(10'd1022, 4'd2);
    wait_drained();
    write_all(8'd0, 32'd655360, 32'd655360, 32'd655360);
    send_sample(10'd200, 4'd1);
    send_sample(10'd200, 4'd7);
    wait_drained();

    // random phases, cycling through the idle and stall patterns
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      write_all(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                random_ro(), random_ro(), random_ro());
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(9) == 0)
          send_sample(10'($urandom()), 4'($urandom()));
        else
          send_sample(10'($urandom_range(1, 1022)), 4'($urandom_range(0, 11)));
        // in phase 5, after sample 20, pause until the block has emptied
        if (ph == 5 && n == 20) begin
          in_valid_i <= 1'b0;
          do @(negedge clk_i); while (pending != 0);
          @(posedge clk_i);
        end
      end
      wait_drained();
    end

    if (fail_count == 0) $display("gas_ppm_from_sensor_sample_core: match");
    else $display("gas_ppm_from_sensor_sample_core: mismatch");
    $finish;
  end

  // end the run if it hangs
  initial begin
    #200ms;
    $display("gas_ppm_from_sensor_sample_core: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/gpfs_pkg.sv
rtl/core/gpfs_front.sv
rtl/core/gpfs_fifo.sv
rtl/core/gpfs_div.sv
rtl/core/gpfs_log2.sv
rtl/core/gpfs_back.sv
rtl/core/gas_ppm_from_sensor_sample_core.sv
tb/gas_ppm_from_sensor_sample_core_checker.sv
tb/gas_ppm_from_sensor_sample_core_test.sv
